### design/window_point_unproject_unit_macros.svh
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef WINDOW_POINT_UNPROJECT_UNIT_MACROS_SVH
`define WINDOW_POINT_UNPROJECT_UNIT_MACROS_SVH

// same-cycle implication
`define WPU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window point unproject check failed");

// next-cycle implication
`define WPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window point unproject check failed");

`endif

### design/wpu_pkg.sv
`default_nettype none
package wpu_pkg;

    localparam int COORD_BITS = 12;
    localparam int COEF_BITS  = 16;

    localparam int FRAC_BITS = 16;
    localparam int FRAC_ONE  = 65536;
    localparam int VP_BITS   = 13;
    localparam int IN_XY_BITS = 12;
    localparam int XB        = (COORD_BITS < IN_XY_BITS) ? COORD_BITS : IN_XY_BITS;
    localparam int PQ_BITS   = XB + 17;
    localparam int N_BITS    = PQ_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + N_BITS;
    localparam int U_BITS    = PROD_BITS + 2;
    localparam int Q_BITS    = 32;

    localparam int NORM_DEPTH = PQ_BITS + 2;
    localparam int XF_DEPTH   = 2;
    localparam int DIV_DEPTH  = Q_BITS + 3;
    localparam int DEPTH      = NORM_DEPTH + XF_DEPTH + DIV_DEPTH;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROW0   = 3'd2;
    localparam logic [2:0] REG_ROW1   = 3'd3;
    localparam logic [2:0] REG_ROW2   = 3'd4;
    localparam logic [2:0] REG_ROW3   = 3'd5;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [N_BITS-1:0] nval_t;
    typedef logic signed [U_BITS-1:0] uval_t;

    typedef struct packed {
        nval_t x;
        nval_t y;
        nval_t z;
    } ndc_t;

    function automatic logic signed [COEF_BITS-1:0] coef_of(input logic [63:0] row,
                                                             input logic [1:0] col);
        coef_of = $signed(row[16*col +: COEF_BITS]);
    endfunction

endpackage
`default_nettype wire

### design/wpu_norm.sv
`default_nettype none
module wpu_norm (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [11:0]                  window_x,
    input  wire logic [11:0]                  window_y,
    input  wire logic [15:0]                  depth_value,
    input  wire logic [wpu_pkg::VP_BITS-1:0]  div_w,
    input  wire logic [wpu_pkg::VP_BITS-1:0]  div_h,
    output wpu_pkg::ndc_t                     ndc
);

    // index 0 holds the registered request, index s+1 the result of step s
    logic [wpu_pkg::VP_BITS-1:0] rem_reg  [2][wpu_pkg::PQ_BITS+1];
    logic [wpu_pkg::VP_BITS-1:0] rem_next [2][wpu_pkg::PQ_BITS+1];
    logic [wpu_pkg::PQ_BITS-1:0] acc_reg  [2][wpu_pkg::PQ_BITS+1];
    logic [wpu_pkg::PQ_BITS-1:0] acc_next [2][wpu_pkg::PQ_BITS+1];
    logic [15:0]                 d_reg    [wpu_pkg::PQ_BITS+1];
    logic [wpu_pkg::VP_BITS-1:0] dv       [2];
    wpu_pkg::ndc_t               ndc_reg;
    wpu_pkg::ndc_t               ndc_next;

    assign dv[0] = div_w;
    assign dv[1] = div_h;

    always_comb
    begin
        logic [wpu_pkg::VP_BITS:0] trial;
        logic                      ge;
        rem_next[0][0] = '0;
        rem_next[1][0] = '0;
        acc_next[0][0] = {window_x[wpu_pkg::XB-1:0], 17'b0};
        acc_next[1][0] = {window_y[wpu_pkg::XB-1:0], 17'b0};
        for (int l = 0; l < 2; l++)
        begin
            for (int s = 0; s < wpu_pkg::PQ_BITS; s++)
            begin
                trial = {rem_reg[l][s], acc_reg[l][s][wpu_pkg::PQ_BITS-1]};
                ge    = trial >= {1'b0, dv[l]};
                rem_next[l][s+1] = ge ? wpu_pkg::VP_BITS'(trial - {1'b0, dv[l]})
                                      : trial[wpu_pkg::VP_BITS-1:0];
                acc_next[l][s+1] = {acc_reg[l][s][wpu_pkg::PQ_BITS-2:0], ge};
            end
        end
        ndc_next.x = $signed({1'b0, acc_reg[0][wpu_pkg::PQ_BITS]})
                   - $signed(wpu_pkg::N_BITS'(wpu_pkg::FRAC_ONE));
        ndc_next.y = $signed(wpu_pkg::N_BITS'(wpu_pkg::FRAC_ONE))
                   - $signed({1'b0, acc_reg[1][wpu_pkg::PQ_BITS]});
        ndc_next.z = $signed(wpu_pkg::N_BITS'({d_reg[wpu_pkg::PQ_BITS], 1'b0}))
                   - $signed(wpu_pkg::N_BITS'(wpu_pkg::FRAC_ONE));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            d_reg[0] <= depth_value;
            for (int s = 1; s <= wpu_pkg::PQ_BITS; s++)
            begin
                d_reg[s] <= d_reg[s-1];
            end
            ndc_reg <= ndc_next;
        end
    end

    assign ndc = ndc_reg;

endmodule
`default_nettype wire

### design/wpu_xform.sv
`default_nettype none
module wpu_xform (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] row [4],
    input  wpu_pkg::ndc_t    ndc,
    output wpu_pkg::uval_t   u [4]
);

    logic signed [wpu_pkg::PROD_BITS-1:0] prod_reg  [4][4];
    logic signed [wpu_pkg::PROD_BITS-1:0] prod_next [4][4];
    wpu_pkg::uval_t                       u_reg     [4];
    wpu_pkg::uval_t                       u_next    [4];
    wpu_pkg::nval_t                       nv        [3];

    assign nv[0] = ndc.x;
    assign nv[1] = ndc.y;
    assign nv[2] = ndc.z;

    always_comb
    begin
        logic signed [wpu_pkg::COEF_BITS-1:0] cf;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cf = wpu_pkg::coef_of(row[r], 2'(c));
                prod_next[r][c] = wpu_pkg::PROD_BITS'(cf) * wpu_pkg::PROD_BITS'(nv[c]);
            end
            // w column of the point is exactly one
            cf = wpu_pkg::coef_of(row[r], 2'd3);
            prod_next[r][3] = wpu_pkg::PROD_BITS'(cf) <<< wpu_pkg::FRAC_BITS;
            u_next[r] = wpu_pkg::U_BITS'(prod_reg[r][0]) + wpu_pkg::U_BITS'(prod_reg[r][1])
                      + wpu_pkg::U_BITS'(prod_reg[r][2]) + wpu_pkg::U_BITS'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            u_reg    <= u_next;
        end
    end

    assign u = u_reg;

endmodule
`default_nettype wire

### design/wpu_div.sv
`default_nettype none
module wpu_div (
    input  wire logic         clk,
    input  wire logic         en,
    input  wpu_pkg::uval_t    num,
    input  wpu_pkg::uval_t    den,
    output logic signed [31:0] res
);

    typedef struct packed {
        logic neg;
        logic dz;
        logic npos;
        logic nneg;
        logic ovf;
    } div_flag_t;

    logic [wpu_pkg::U_BITS-1:0] mn_reg;
    logic [wpu_pkg::U_BITS-1:0] md0_reg;
    div_flag_t                  fl0_reg;

    logic [wpu_pkg::U_BITS-1:0] rem_reg  [wpu_pkg::Q_BITS+1];
    logic [wpu_pkg::U_BITS-1:0] rem_next [wpu_pkg::Q_BITS+1];
    logic [wpu_pkg::Q_BITS-1:0] acc_reg  [wpu_pkg::Q_BITS+1];
    logic [wpu_pkg::Q_BITS-1:0] acc_next [wpu_pkg::Q_BITS+1];
    logic [wpu_pkg::U_BITS-1:0] md_reg   [wpu_pkg::Q_BITS+1];
    div_flag_t                  fl_reg   [wpu_pkg::Q_BITS+1];
    div_flag_t                  fl_first;
    logic signed [31:0]         res_reg;
    logic signed [31:0]         res_next;
    logic [wpu_pkg::Q_BITS-1:0] q;
    div_flag_t                  ff;

    always_comb
    begin
        logic [wpu_pkg::U_BITS:0] trial;
        logic                     ge;
        // quotient fits 32 bits only when mn < md * 2^16
        fl_first     = fl0_reg;
        fl_first.ovf = {16'b0, mn_reg} >= {md0_reg, 16'b0};
        rem_next[0]  = wpu_pkg::U_BITS'(mn_reg >> 16);
        acc_next[0]  = {mn_reg[15:0], 16'b0};
        for (int s = 0; s < wpu_pkg::Q_BITS; s++)
        begin
            trial = {rem_reg[s], acc_reg[s][wpu_pkg::Q_BITS-1]};
            ge    = trial >= {1'b0, md_reg[s]};
            rem_next[s+1] = ge ? wpu_pkg::U_BITS'(trial - {1'b0, md_reg[s]})
                               : trial[wpu_pkg::U_BITS-1:0];
            acc_next[s+1] = {acc_reg[s][wpu_pkg::Q_BITS-2:0], ge};
        end

        q  = acc_reg[wpu_pkg::Q_BITS];
        ff = fl_reg[wpu_pkg::Q_BITS];
        if (ff.dz)
            res_next = ff.npos ? wpu_pkg::SAT_MAX : (ff.nneg ? wpu_pkg::SAT_MIN : 32'sd0);
        else if (ff.ovf)
            res_next = ff.neg ? wpu_pkg::SAT_MIN : wpu_pkg::SAT_MAX;
        else if (ff.neg)
            res_next = (q > 32'h8000_0000) ? wpu_pkg::SAT_MIN : $signed(32'(0 - q));
        else
            res_next = q[31] ? wpu_pkg::SAT_MAX : $signed(q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mn_reg       <= num[wpu_pkg::U_BITS-1] ? wpu_pkg::U_BITS'(-num)
                                                   : wpu_pkg::U_BITS'(num);
            md0_reg      <= den[wpu_pkg::U_BITS-1] ? wpu_pkg::U_BITS'(-den)
                                                   : wpu_pkg::U_BITS'(den);
            fl0_reg.neg  <= num[wpu_pkg::U_BITS-1] ^ den[wpu_pkg::U_BITS-1];
            fl0_reg.dz   <= den == '0;
            fl0_reg.npos <= !num[wpu_pkg::U_BITS-1] && (num != '0);
            fl0_reg.nneg <= num[wpu_pkg::U_BITS-1];
            fl0_reg.ovf  <= 1'b0;

            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            md_reg[0] <= md0_reg;
            fl_reg[0] <= fl_first;
            for (int s = 1; s <= wpu_pkg::Q_BITS; s++)
            begin
                md_reg[s] <= md_reg[s-1];
                fl_reg[s] <= fl_reg[s-1];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### design/window_point_unproject_unit.sv
// channel  | handshake             | payload
// in       | in_valid / in_stall   | window_x, window_y, depth_value
// out      | out_valid / out_stall | object_x, object_y, object_z, w_zero
// cfg      | cfg_we                | cfg_index, cfg_data
//
// one request per cycle unless in_stall holds it off; a request passes through
// the viewport quotients (one register per quotient bit plus an entry and an exit
// register), the matrix product and the w divider, which retires one quotient
// bit per stage.
// rst_n clears the valid pipeline and loads the registers' reset values.
// a held result freezes every stage, so in_stall follows out_valid && out_stall.
`default_nettype none
module window_point_unproject_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [11:0]  window_x,
    input  wire logic [11:0]  window_y,
    input  wire logic [15:0]  depth_value,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic signed [31:0] object_x,
    output logic signed [31:0] object_y,
    output logic signed [31:0] object_z,
    output logic              w_zero
);

    logic [wpu_pkg::VP_BITS-1:0] width_reg;
    logic [wpu_pkg::VP_BITS-1:0] height_reg;
    logic [63:0]                 row_reg [4];
    logic [wpu_pkg::VP_BITS-1:0] div_w;
    logic [wpu_pkg::VP_BITS-1:0] div_h;
    logic [wpu_pkg::DEPTH-1:0]   v_reg;
    logic [wpu_pkg::DIV_DEPTH-1:0] z_reg;
    logic                        en;
    wpu_pkg::ndc_t               ndc;
    wpu_pkg::uval_t              u [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1920;
            height_reg <= 13'd1080;
            row_reg[0] <= 64'h0000_0000_0000_1000;
            row_reg[1] <= 64'h0000_0000_1000_0000;
            row_reg[2] <= 64'h0000_1000_0000_0000;
            row_reg[3] <= 64'h1000_0000_0000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wpu_pkg::REG_WIDTH:  width_reg  <= cfg_data[wpu_pkg::VP_BITS-1:0];
                wpu_pkg::REG_HEIGHT: height_reg <= cfg_data[wpu_pkg::VP_BITS-1:0];
                wpu_pkg::REG_ROW0:   row_reg[0] <= cfg_data;
                wpu_pkg::REG_ROW1:   row_reg[1] <= cfg_data;
                wpu_pkg::REG_ROW2:   row_reg[2] <= cfg_data;
                wpu_pkg::REG_ROW3:   row_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero viewport acts as one
    assign div_w = (width_reg  == '0) ? wpu_pkg::VP_BITS'(1) : width_reg;
    assign div_h = (height_reg == '0) ? wpu_pkg::VP_BITS'(1) : height_reg;

    assign out_valid = v_reg[wpu_pkg::DEPTH-1];
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[wpu_pkg::DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            z_reg <= {z_reg[wpu_pkg::DIV_DEPTH-2:0], u[3] == '0};
    end

    assign w_zero = z_reg[wpu_pkg::DIV_DEPTH-1];

    wpu_norm u_norm (
        .clk         (clk),
        .en          (en),
        .window_x    (window_x),
        .window_y    (window_y),
        .depth_value (depth_value),
        .div_w       (div_w),
        .div_h       (div_h),
        .ndc         (ndc)
    );

    wpu_xform u_xform (
        .clk (clk),
        .en  (en),
        .row (row_reg),
        .ndc (ndc),
        .u   (u)
    );

    wpu_div u_div_x (.clk(clk), .en(en), .num(u[0]), .den(u[3]), .res(object_x));
    wpu_div u_div_y (.clk(clk), .en(en), .num(u[1]), .den(u[3]), .res(object_y));
    wpu_div u_div_z (.clk(clk), .en(en), .num(u[2]), .den(u[3]), .res(object_z));

endmodule
`default_nettype wire

### design/wpu_checker.sv
`default_nettype none
`include "window_point_unproject_unit_macros.svh"
module wpu_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_stall,
    input wire logic         out_valid,
    input wire logic         out_stall,
    input wire logic signed [31:0] object_x,
    input wire logic         w_zero
);

    logic x_sat;

    assign x_sat = (object_x == wpu_pkg::SAT_MAX) || (object_x == wpu_pkg::SAT_MIN)
                || (object_x == 32'sd0);

    `WPU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `WPU_ASSERT_NOW(a_in_free, !out_valid, !in_stall)
    `WPU_ASSERT_NOW(a_in_block, out_valid && out_stall, in_stall)
    `WPU_ASSERT_NOW(a_wz_sat, out_valid && w_zero, x_sat)

endmodule

bind window_point_unproject_unit wpu_checker u_wpu_checker (.*);
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASE_ITEMS = 60;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] d;
    } pixel_t;

    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic               wz;
    } point_t;

    typedef struct {
        logic   zero_w_matrix;
        pixel_t px;
        logic   typed;
        point_t pt;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [11:0] window_x;
    logic [11:0] window_y;
    logic [15:0] depth_value;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] object_x;
    logic signed [31:0] object_y;
    logic signed [31:0] object_z;
    logic w_zero;

    window_point_unproject_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .window_x(window_x),
        .window_y(window_y),
        .depth_value(depth_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .object_x(object_x),
        .object_y(object_y),
        .object_z(object_z),
        .w_zero(w_zero)
    );

    // local copy of the register file
    logic [12:0] vp_width;
    logic [12:0] vp_height;
    logic [63:0] mat_rows [4];

    point_t pending_points [$];
    int errors;
    bit sender_quiet;
    bit receiver_quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic longint coef(input int r, input int c);
        longint v;
        v = longint'(mat_rows[r][16*c +: 16]) & ((longint'(1) << wpu_pkg::COEF_BITS) - 1);
        if (v[wpu_pkg::COEF_BITS-1])
            v -= longint'(1) << wpu_pkg::COEF_BITS;
        return v;
    endfunction

    function automatic logic signed [31:0] div_sat(input longint num, input longint den,
                                                   inout logic zero);
        longint unsigned mn;
        longint unsigned md;
        longint unsigned q;
        bit neg;
        if (den == 0)
        begin
            zero = 1'b1;
            if (num > 0)
                return wpu_pkg::SAT_MAX;
            if (num < 0)
                return wpu_pkg::SAT_MIN;
            return 32'sd0;
        end
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (mn * 65536) / md;
        if (neg)
            return (q > 64'd2147483648) ? wpu_pkg::SAT_MIN : 32'(-longint'(q));
        return (q > 64'd2147483647) ? wpu_pkg::SAT_MAX : 32'(q);
    endfunction

    function automatic point_t unproject(input pixel_t px);
        longint unsigned x;
        longint unsigned y;
        longint unsigned wd;
        longint unsigned hd;
        longint n [4];
        longint u [4];
        logic zero;
        point_t p;
        x = longint'(px.x) & ((longint'(1) << wpu_pkg::COORD_BITS) - 1);
        y = longint'(px.y) & ((longint'(1) << wpu_pkg::COORD_BITS) - 1);
        wd = (vp_width == 0) ? 1 : vp_width;
        hd = (vp_height == 0) ? 1 : vp_height;
        n[0] = longint'((x << 17) / wd) - 65536;
        n[1] = 65536 - longint'((y << 17) / hd);
        n[2] = longint'(px.d) * 2 - 65536;
        n[3] = 65536;
        for (int r = 0; r < 4; r++)
        begin
            u[r] = 0;
            for (int c = 0; c < 4; c++)
                u[r] += coef(r, c) * n[c];
        end
        zero = 1'b0;
        p.ox = div_sat(u[0], u[3], zero);
        p.oy = div_sat(u[1], u[3], zero);
        p.oz = div_sat(u[2], u[3], zero);
        p.wz = zero;
        return p;
    endfunction

    task automatic set_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wpu_pkg::REG_WIDTH: vp_width = data[12:0];
            wpu_pkg::REG_HEIGHT: vp_height = data[12:0];
            wpu_pkg::REG_ROW0: mat_rows[0] = data;
            wpu_pkg::REG_ROW1: mat_rows[1] = data;
            wpu_pkg::REG_ROW2: mat_rows[2] = data;
            wpu_pkg::REG_ROW3: mat_rows[3] = data;
            default: ;
        endcase
    endtask

    // hold off new requests until the pipeline has emptied
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (wpu_pkg::DEPTH + 5) @(negedge clk);
    endtask

    task automatic send(input pixel_t px, input logic typed, input point_t pt);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        window_x <= px.x;
        window_y <= px.y;
        depth_value <= px.d;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_points.push_back(typed ? pt : unproject(px));
        @(negedge clk);
    endtask

    function automatic logic [63:0] pack_row(input logic [15:0] c0, input logic [15:0] c1,
                                             input logic [15:0] c2, input logic [15:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed(12'($urandom)));
            2: return 16'h1000;
            default: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
        endcase
    endfunction

    // receiver: random stall before each result
    initial
    begin
        int hold;
        point_t want;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 15) == 0)
                receiver_quiet = ~receiver_quiet;
            hold = receiver_quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_points.size() == 0)
                report_mismatch("result with nothing outstanding");
            else
            begin
                want = pending_points.pop_front();
                if (object_x !== want.ox)
                    report_mismatch($sformatf("object_x %0d want %0d", object_x, want.ox));
                if (object_y !== want.oy)
                    report_mismatch($sformatf("object_y %0d want %0d", object_y, want.oy));
                if (object_z !== want.oz)
                    report_mismatch($sformatf("object_z %0d want %0d", object_z, want.oz));
                if (w_zero !== want.wz)
                    report_mismatch($sformatf("w_zero %0b want %0b", w_zero, want.wz));
            end
        end
    end

    // watchdog on handshake progress
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        directed_row_t rows [$];
        directed_row_t row;
        point_t none;
        pixel_t px;
        logic cur_zero_w;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = wpu_pkg::REG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        window_x = '0;
        window_y = '0;
        depth_value = '0;
        errors = 0;
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
        vp_width = 13'd1920;
        vp_height = 13'd1080;
        mat_rows[0] = 64'h0000_0000_0000_1000;
        mat_rows[1] = 64'h0000_0000_1000_0000;
        mat_rows[2] = 64'h0000_1000_0000_0000;
        mat_rows[3] = 64'h1000_0000_0000_0000;
        none = '{0, 0, 0, 0};

        // identity matrix: screen center maps to origin, corner to (-1, 1, -1)
        rows.push_back('{0, '{12'd960, 12'd540, 16'd32768}, 1, '{0, 0, 0, 0}});
        rows.push_back('{0, '{12'd0, 12'd0, 16'd0}, 1, '{-65536, 65536, -65536, 0}});
        rows.push_back('{0, '{12'd4095, 12'd4095, 16'hFFFF}, 0, none});
        rows.push_back('{0, '{12'd1920, 12'd1080, 16'd65535}, 0, none});
        rows.push_back('{0, '{12'd1919, 12'd1079, 16'd1}, 0, none});
        rows.push_back('{0, '{12'hAAA, 12'h555, 16'hAAAA}, 0, none});
        rows.push_back('{0, '{12'h555, 12'hAAA, 16'h5555}, 0, none});
        // w row zeroed: saturation by sign of numerator, flag set
        rows.push_back('{1, '{12'd0, 12'd0, 16'd0}, 1,
                         '{wpu_pkg::SAT_MIN, wpu_pkg::SAT_MAX, wpu_pkg::SAT_MIN, 1}});
        rows.push_back('{1, '{12'd960, 12'd540, 16'd32768}, 1, '{0, 0, 0, 1}});
        rows.push_back('{1, '{12'd4095, 12'd4095, 16'hFFFF}, 0, none});
        rows.push_back('{1, '{12'd1920, 12'd0, 16'd12345}, 0, none});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cur_zero_w = 1'b0;
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.zero_w_matrix != cur_zero_w)
            begin
                settle();
                set_reg(wpu_pkg::REG_ROW3,
                        row.zero_w_matrix ? 64'd0 : 64'h1000_0000_0000_0000);
                cur_zero_w = row.zero_w_matrix;
            end
            send(row.px, row.typed, row.pt);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    set_reg(wpu_pkg::REG_WIDTH, 64'd0);
                    set_reg(wpu_pkg::REG_HEIGHT, 64'd0);
                end
                1:
                begin
                    set_reg(wpu_pkg::REG_WIDTH, 64'h1FFF);
                    set_reg(wpu_pkg::REG_HEIGHT, 64'h1FFF);
                end
                2:
                begin
                    set_reg(wpu_pkg::REG_WIDTH, 64'd4096);
                    set_reg(wpu_pkg::REG_HEIGHT, 64'd1);
                end
                default:
                begin
                    set_reg(wpu_pkg::REG_WIDTH, {$urandom, $urandom});
                    set_reg(wpu_pkg::REG_HEIGHT, 64'($urandom_range(1, 4096)));
                end
            endcase
            // junk into unmapped indexes must not disturb anything
            set_reg(REG_SPARE_A, {$urandom, $urandom});
            set_reg(REG_SPARE_B, {$urandom, $urandom});
            if (phase == 1)
            begin
                set_reg(wpu_pkg::REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
                set_reg(wpu_pkg::REG_ROW1, 64'h8000_8000_8000_8000);
                set_reg(wpu_pkg::REG_ROW2, 64'h7FFF_8000_7FFF_8000);
                set_reg(wpu_pkg::REG_ROW3, 64'h0001_0000_0000_0000);
            end
            else if (phase == 2)
            begin
                set_reg(wpu_pkg::REG_ROW0, 64'd0);
                set_reg(wpu_pkg::REG_ROW1, {$urandom, $urandom});
                set_reg(wpu_pkg::REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
                set_reg(wpu_pkg::REG_ROW3, 64'd0);
            end
            else
            begin
                set_reg(wpu_pkg::REG_ROW0,
                        pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
                set_reg(wpu_pkg::REG_ROW1,
                        pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
                set_reg(wpu_pkg::REG_ROW2,
                        pack_row(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
                // w row: small coefficients on half of the phases so w sometimes lands on zero
                if ($urandom_range(0, 1))
                    set_reg(wpu_pkg::REG_ROW3, pack_row(16'($signed(3'($urandom))),
                                               16'($signed(3'($urandom))), 16'd0, 16'd0));
                else
                    set_reg(wpu_pkg::REG_ROW3, pack_row(rand_coef(), rand_coef(),
                                                        rand_coef(), rand_coef()));
            end
            sender_quiet = (phase == 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (!sender_quiet && $urandom_range(0, 20) == 0)
                    receiver_quiet = ~receiver_quiet;
                px.x = 12'($urandom);
                px.y = 12'($urandom);
                px.d = 16'($urandom);
                if ($urandom_range(0, 4) == 0)
                begin
                    px.x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    px.d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                send(px, 1'b0, none);
            end
        end

        settle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
